FILE: rtl/stable_priority_queue_macros.svh
// assertion macros for the stable priority queue
// used by the datapath module, no other dependencies
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq: same-cycle check failed");

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq: next-cycle check failed");

`endif

FILE: rtl/spq_pkg.sv
// shared types and constants for the stable priority queue
// no dependencies; used by every module of the block
package spq_pkg;

  // default sizing
  localparam int CAPACITY_DEF  = 64;
  localparam int PRIO_BITS_DEF = 2;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int IN_PRIO_W = 2;
  localparam int FILL_W    = 7;

  // operation codes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // input item
  typedef struct packed {
    logic                 mode;
    logic [BYTE_W-1:0]    in_byte;
    logic [IN_PRIO_W-1:0] in_priority;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              dropped;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture a result into the output register
    logic shift_in;   // insert the new entry
    logic shift_out;  // remove the front entry
    logic drop;       // enqueue refused, store full
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } status_t;

endpackage

FILE: rtl/spq_ctrl.sv
// controller for the stable priority queue: handshake and command decode
// depends on spq_pkg
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  output logic             out_valid,
  input  logic             out_ready,
  input  spq_pkg::status_t status,
  output spq_pkg::cmd_t    cmd
);

  // state codes: output register empty or holding a result
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // a new item goes in whenever the output register is free or being drained
  assign in_ready  = (state_r == ST_IDLE) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == ST_HOLD);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.shift_in  = accept && (in_mode == spq_pkg::MODE_ENQ) && !status.full;
    cmd.drop      = accept && (in_mode == spq_pkg::MODE_ENQ) && status.full;
    cmd.shift_out = accept && (in_mode == spq_pkg::MODE_DEQ) && !status.empty;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!accept && out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/spq_datapath.sv
// datapath for the stable priority queue: shift-insert cell row, count, result register
// depends on spq_pkg and stable_priority_queue_macros.svh
`include "stable_priority_queue_macros.svh"

module spq_datapath #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spq_pkg::cmd_t        cmd,
  input  spq_pkg::in_item_t    in_data,
  output spq_pkg::status_t     status,
  output spq_pkg::out_item_t   out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [spq_pkg::BYTE_W-1:0] data_r   [CAPACITY];
  logic [PRIO_BITS-1:0]       prio_r   [CAPACITY];
  logic [spq_pkg::BYTE_W-1:0] data_nxt [CAPACITY];
  logic [PRIO_BITS-1:0]       prio_nxt [CAPACITY];
  logic [CAPACITY-1:0]        ge;
  logic [PRIO_BITS-1:0]       prio_new;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  spq_pkg::out_item_t         out_r;
  spq_pkg::out_item_t         out_nxt;

  // bits above PRIO_BITS are ignored, narrower inputs zero-extend
  assign prio_new = PRIO_BITS'(in_data.in_priority);

  assign status.full  = (count_r == CW'(CAPACITY));
  assign status.empty = (count_r == '0);

  // per-cell compare: held entry ranks ahead of the new one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ge[i] = (CW'(i) < count_r) && (prio_r[i] >= prio_new);

    // each cell keeps, takes the new entry or takes a neighbor
    always_comb begin
      data_nxt[i] = data_r[i];
      prio_nxt[i] = prio_r[i];
      if (cmd.shift_in) begin
        if (!ge[i]) begin
          if (i == 0) begin
            data_nxt[i] = in_data.in_byte;
            prio_nxt[i] = prio_new;
          end else if (ge[(i == 0) ? 0 : i-1]) begin
            data_nxt[i] = in_data.in_byte;
            prio_nxt[i] = prio_new;
          end else begin
            data_nxt[i] = data_r[(i == 0) ? 0 : i-1];
            prio_nxt[i] = prio_r[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd.shift_out && (i < CAPACITY - 1)) begin
        data_nxt[i] = data_r[(i < CAPACITY - 1) ? i+1 : i];
        prio_nxt[i] = prio_r[(i < CAPACITY - 1) ? i+1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.shift_in || cmd.shift_out) begin
        data_r[i] <= data_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.shift_in)       count_nxt = count_r + CW'(1);
    else if (cmd.shift_out) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result item
  always_comb begin
    out_nxt            = '0;
    out_nxt.out_byte   = cmd.shift_out ? data_r[0] : '0;
    out_nxt.out_valid  = cmd.shift_out;
    out_nxt.dropped    = cmd.drop;
    out_nxt.fill_count = spq_pkg::FILL_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_r <= out_nxt;
  end

  assign out_data = out_r;

  // checks
  `SPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `SPQ_ASSERT_NXT(a_drop_keeps, clk, rst_n, cmd.drop, $stable(count_r))
  `SPQ_ASSERT_NXT(a_deq_count, clk, rst_n, cmd.shift_out, count_r == $past(count_r) - CW'(1))
  `SPQ_ASSERT_IMP(a_drop_full, clk, rst_n, cmd.drop, status.full && !cmd.shift_in)

endmodule

FILE: rtl/stable_priority_queue.sv
// top level of the stable priority queue of bytes
// depends on spq_pkg, spq_ctrl and spq_datapath
//
//   channel  handshake            payload
//   in       in_valid / in_ready  in_data   (spq_pkg::in_item_t)
//   out      out_valid/ out_ready out_data  (spq_pkg::out_item_t)
//
// one item per cycle unless out_ready stalls: the cell row compares all entries
// with the new one in parallel and shifts; the result enters the output register
// and shows on the next cycle. reset (rst_n low, synchronous) empties the queue.
// a new item is taken while the output register is empty or being drained,
// so a stall on out_ready holds the input only once a result is waiting.
module stable_priority_queue #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);

  spq_pkg::cmd_t    cmd;
  spq_pkg::status_t status;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY  (CAPACITY),
    .PRIO_BITS (PRIO_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule

FILE: test/spq_order_tracker.sv
`timescale 1ns / 100ps
// expected-result tracking for the stable priority queue testbench
// depends on spq_pkg; used by tb_top
package spq_tb_pkg;

  // one stored entry: data byte and its priority
  typedef struct packed {
    logic [spq_pkg::BYTE_W-1:0]        data;
    logic [spq_pkg::PRIO_BITS_DEF-1:0] prio;
  } queue_cell_t;

  class spq_order_tracker;
    queue_cell_t        held_cells[$];       // front is served first
    spq_pkg::out_item_t pending_results[$];  // oldest first
    int                 capacity;
    int                 fail_cnt;

    function new(int cap);
      capacity = cap;
      fail_cnt = 0;
    endfunction

    // apply an accepted item to the mirror and queue its result
    function void note_item(spq_pkg::in_item_t it);
      spq_pkg::out_item_t res;
      queue_cell_t        entry;
      int                 pos;
      res = '0;
      if (it.mode == spq_pkg::MODE_ENQ) begin
        if (held_cells.size() >= capacity) begin
          res.dropped = 1'b1;
        end else begin
          entry.data = it.in_byte;
          entry.prio = it.in_priority[spq_pkg::PRIO_BITS_DEF-1:0];
          // goes behind every entry of greater or equal priority
          pos = 0;
          while (pos < held_cells.size() && held_cells[pos].prio >= entry.prio) pos++;
          held_cells.insert(pos, entry);
        end
      end else if (held_cells.size() > 0) begin
        res.out_byte  = held_cells[0].data;
        res.out_valid = 1'b1;
        void'(held_cells.pop_front());
      end
      res.fill_count = spq_pkg::FILL_W'(held_cells.size());
      pending_results.push_back(res);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fail_cnt++;
      end
    endfunction

    // compare a delivered result with the oldest expectation
    function void check_item(spq_pkg::out_item_t got);
      spq_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %p", got);
        fail_cnt++;
        return;
      end
      want = pending_results.pop_front();
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("out_valid", want.out_valid, got.out_valid);
      cmp_field("dropped", want.dropped, got.dropped);
      cmp_field("fill_count", want.fill_count, got.fill_count);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// testbench top for stable_priority_queue: directed and random items with
// random idling on both channels; depends on spq_pkg and spq_tb_pkg
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 60;    // accepted items before the long stall
  localparam int HOLD_LEN    = 300;   // receiver hold-off in cycles
  localparam int TAIL_CYCLES = 20;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  spq_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_item_t out_data;

  spq_tb_pkg::spq_order_tracker tracker = new(spq_pkg::CAPACITY_DEF);

  int snd_idle_pct = 28;
  int rcv_idle_pct = 48;
  int taken_cnt    = 0;
  int cycle_cnt    = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  stable_priority_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off once HOLD_AT items are accepted
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.note_item(in_data);
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid && out_ready) tracker.check_item(out_data);
    end
  end

  function automatic spq_pkg::in_item_t mk_item(logic mode, int data, int prio);
    spq_pkg::in_item_t it;
    it.mode        = mode;
    it.in_byte     = spq_pkg::BYTE_W'(data);
    it.in_priority = spq_pkg::IN_PRIO_W'(prio);
    return it;
  endfunction

  // offer one item, idling at random first, and wait for acceptance
  task automatic send_item(spq_pkg::in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // a run of items with a fixed enqueue share; dequeue payload is random junk
  task automatic run_burst(int n_items, int enq_pct);
    int k;
    for (k = 0; k < n_items; k++) begin
      send_item(mk_item(($urandom_range(99) < enq_pct) ? spq_pkg::MODE_ENQ
                                                        : spq_pkg::MODE_DEQ,
                        $urandom_range(255), $urandom_range(3)));
    end
  endtask

  // bursts that swing between filling, mixing and draining
  task automatic run_random(int n_items);
    int left;
    int burst;
    int enq_pct;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(100, 30);
      if (burst > left) burst = left;
      case ($urandom_range(2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      run_burst(burst, enq_pct);
      left -= burst;
    end
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dequeue from empty, then every priority with byte extremes and ties
    send_item(mk_item(spq_pkg::MODE_DEQ, 8'hA5, 2));
    send_item(mk_item(spq_pkg::MODE_ENQ, 8'h00, 0));
    send_item(mk_item(spq_pkg::MODE_ENQ, 8'hFF, 3));
    send_item(mk_item(spq_pkg::MODE_ENQ, 8'h55, 1));
    send_item(mk_item(spq_pkg::MODE_ENQ, 8'hAA, 2));
    send_item(mk_item(spq_pkg::MODE_ENQ, 8'h11, 3));
    send_item(mk_item(spq_pkg::MODE_ENQ, 8'h22, 0));
    send_item(mk_item(spq_pkg::MODE_ENQ, 8'h33, 2));
    repeat (7) send_item(mk_item(spq_pkg::MODE_DEQ, $urandom_range(255),
                                 $urandom_range(3)));
    send_item(mk_item(spq_pkg::MODE_DEQ, 8'hFF, 3));
    send_item(mk_item(spq_pkg::MODE_DEQ, 8'h00, 0));

    // sender idles less than receiver; fill early to hit the full store
    run_burst(100, 92);
    run_random(217);

    // the other way round
    snd_idle_pct = 48;
    rcv_idle_pct = 28;
    run_random(317);

    // no idling
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(317);
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
